@@ design/ttlc_pkg.sv @@
package ttlc_pkg;

   // Sizing of the slot array.
   localparam int CAPACITY       = 16;
   localparam int CHECK_INTERVAL = 5;
   localparam int IDX_W          = $clog2(CAPACITY);
   localparam int CNT_W          = $clog2(CAPACITY + 1);
   localparam int CMP_W          = (CNT_W > 5) ? CNT_W : 5;

   // Request codes.
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_CHECK  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_MAX_ENTRIES = 1'b0;
   localparam logic CSR_TTL         = 1'b1;

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_INSERTED= 3'd2,
      ST_CHANGED = 3'd3,
      ST_SAME    = 3'd4,
      ST_RAN     = 3'd5,
      ST_SKIPPED = 3'd6,
      ST_INVALID = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MAINT,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      WR_UPDATE,
      WR_INSERT,
      WR_TOUCH,
      WR_EVICT
   } wr_op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] key;
      logic [63:0] name_word;
      logic [31:0] now;
   } req_pkt_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] found_name;
      logic [4:0]  entries_in_use;
      logic [31:0] hits_total;
      logic [31:0] misses_total;
   } rsp_pkt_type;

   // Token that walks down the row of slot cells, gathering search results.
   typedef struct packed {
      logic             live;
      logic             maint;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [63:0]      hit_name;
      logic [31:0]      hit_created;
      logic             free;
      logic [IDX_W-1:0] free_idx;
      logic             old;
      logic [IDX_W-1:0] old_idx;
      logic [31:0]      old_acc;
      logic [CNT_W-1:0] count;
   } probe_type;

   // Write command broadcast to all cells.
   typedef struct packed {
      logic             en;
      wr_op_type        op;
      logic [IDX_W-1:0] idx;
      logic [31:0]      key;
      logic [63:0]      name;
      logic [31:0]      stamp;
   } wr_cmd_type;

endpackage

@@ design/ttlc_cell.sv @@
module ttlc_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ttlc_pkg::IDX_W-1:0] cell_idx,
   input  logic [31:0]               key,
   input  logic [31:0]               now,
   input  logic [31:0]               ttl,
   input  ttlc_pkg::wr_cmd_type      wr,
   input  ttlc_pkg::probe_type       probe_in,
   output ttlc_pkg::probe_type       probe_out
);
   import ttlc_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] key_ff;
   logic [63:0] name_ff;
   logic [31:0] created_ff;
   logic [31:0] accessed_ff;
   probe_type   probe_ff, probe_in_q;
   logic        expired;
   logic        sel;

   assign expired = (now - created_ff) >= ttl;
   assign sel     = wr.en && (wr.idx == cell_idx);

   // Fold this slot into the passing token.
   always_comb begin
      probe_in_q = probe_in;
      valid_in   = valid_ff;
      if (probe_in.live) begin
         if (!probe_in.maint) begin
            if (valid_ff && (key_ff == key) && !probe_in.hit) begin
               probe_in_q.hit         = 1'b1;
               probe_in_q.hit_idx     = cell_idx;
               probe_in_q.hit_name    = name_ff;
               probe_in_q.hit_created = created_ff;
            end
            if (!valid_ff && !probe_in.free) begin
               probe_in_q.free     = 1'b1;
               probe_in_q.free_idx = cell_idx;
            end
            if (valid_ff && (!probe_in.old || (accessed_ff < probe_in.old_acc))) begin
               probe_in_q.old     = 1'b1;
               probe_in_q.old_idx = cell_idx;
               probe_in_q.old_acc = accessed_ff;
            end
         end else begin
            if (valid_ff && expired) begin
               valid_in = 1'b0;
            end
            if (valid_ff && !expired) begin
               probe_in_q.count = probe_in.count + CNT_W'(1);
               if (!probe_in.old || (accessed_ff < probe_in.old_acc)) begin
                  probe_in_q.old     = 1'b1;
                  probe_in_q.old_idx = cell_idx;
                  probe_in_q.old_acc = accessed_ff;
               end
            end
         end
      end
      if (sel) begin
         case (wr.op)
            WR_INSERT: valid_in = 1'b1;
            WR_EVICT:  valid_in = 1'b0;
            default:   valid_in = valid_in;
         endcase
      end
   end

   // Control state of the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_in_q;
      end
   end

   // Slot payload.
   always_ff @(posedge clock) begin
      if (sel) begin
         case (wr.op)
            WR_INSERT: begin
               key_ff      <= wr.key;
               name_ff     <= wr.name;
               created_ff  <= wr.stamp;
               accessed_ff <= wr.stamp;
            end
            WR_UPDATE: begin
               name_ff     <= wr.name;
               created_ff  <= wr.stamp;
               accessed_ff <= wr.stamp;
            end
            WR_TOUCH: accessed_ff <= wr.stamp;
            default: ;
         endcase
      end
   end

   assign probe_out = probe_ff;

endmodule

@@ design/ttl_cache_oldest_evict_unit.sv @@
// Time-to-live key cache with eviction of the oldest-accessed entry. The slots
// sit in a row of cells and a search token moves one cell per clock, so a pass
// over the cache visits every slot in turn. An add takes one pass, a lookup takes
// a search pass and a maintenance pass, a due check one maintenance pass, and a
// skipped check or an invalid request no pass at all.
// One transaction is worked on at a time; a finished result waits in an output
// register. Configuration may only be written while the block is idle.
module ttl_cache_oldest_evict_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ttlc_pkg::req_pkt_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ttlc_pkg::rsp_pkt_type rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata
);
   import ttlc_pkg::*;

   state_type        state_ff, state_in;
   req_pkt_type      req_ff, req_in;
   status_type       status_ff, status_in;
   logic [63:0]      found_ff, found_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      hits_ff, hits_in;
   logic [31:0]      misses_ff, misses_in;
   logic [31:0]      last_check_ff, last_check_in;
   probe_type        head_ff, head_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_pkt_type      rsp_ff, rsp_in;
   logic [4:0]       max_ff;
   logic [31:0]      ttl_ff;
   wr_cmd_type       wr;
   probe_type        chain [CAPACITY+1];
   probe_type        tail;
   logic             check_due;
   logic             is_scan;
   logic             hit_live;
   logic             out_free;

   assign chain[0]  = head_ff;
   assign tail      = chain[CAPACITY];
   assign check_due = (req_data.now - last_check_ff) >= 32'(CHECK_INTERVAL);
   assign is_scan   = ((req_data.req_type == REQ_ADD) && (req_data.name_word != 64'd0))
                      || (req_data.req_type == REQ_LOOKUP);
   assign hit_live  = tail.hit && ((req_ff.now - tail.hit_created) < ttl_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Row of slot cells.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ttlc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(g)),
         .key       (req_ff.key),
         .now       (req_ff.now),
         .ttl       (ttl_ff),
         .wr        (wr),
         .probe_in  (chain[g]),
         .probe_out (chain[g+1])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (is_scan) begin
                  state_in = S_SCAN;
               end else if ((req_data.req_type == REQ_CHECK) && check_due) begin
                  state_in = S_MAINT;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            if (tail.live) begin
               state_in = (req_ff.req_type == REQ_LOOKUP) ? S_MAINT : S_RESP;
            end
         end
         S_MAINT: begin
            if (tail.live) state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      req_in        = req_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      last_check_in = last_check_ff;
      head_in       = '0;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      wr            = '0;
      wr.key        = req_ff.key;
      wr.name       = req_ff.name_word;
      wr.stamp      = req_ff.now;
      req_ready     = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               found_in  = 64'd0;
               status_in = ST_INVALID;
               if (is_scan) begin
                  head_in.live = 1'b1;
               end else if (req_data.req_type == REQ_CHECK) begin
                  if (check_due) begin
                     last_check_in = req_data.now;
                     status_in     = ST_RAN;
                     head_in.live  = 1'b1;
                     head_in.maint = 1'b1;
                  end else begin
                     status_in = ST_SKIPPED;
                  end
               end
            end
         end
         S_SCAN: begin
            if (tail.live) begin
               wr.en = 1'b1;
               if (req_ff.req_type == REQ_LOOKUP) begin
                  head_in.live  = 1'b1;
                  head_in.maint = 1'b1;
                  if (hit_live) begin
                     wr.op     = WR_TOUCH;
                     wr.idx    = tail.hit_idx;
                     found_in  = tail.hit_name;
                     hits_in   = hits_ff + 32'd1;
                     status_in = ST_HIT;
                  end else begin
                     wr.en     = 1'b0;
                     misses_in = misses_ff + 32'd1;
                     status_in = ST_MISS;
                  end
               end else if (tail.hit) begin
                  wr.op     = WR_UPDATE;
                  wr.idx    = tail.hit_idx;
                  status_in = (tail.hit_name != req_ff.name_word) ? ST_CHANGED : ST_SAME;
               end else if (tail.free) begin
                  wr.op     = WR_INSERT;
                  wr.idx    = tail.free_idx;
                  count_in  = count_ff + CNT_W'(1);
                  status_in = ST_INSERTED;
               end else begin
                  wr.op     = WR_INSERT;
                  wr.idx    = tail.old_idx;
                  status_in = ST_INSERTED;
               end
            end
         end
         S_MAINT: begin
            if (tail.live) begin
               count_in = tail.count;
               if (tail.old && (CMP_W'(tail.count) > CMP_W'(max_ff))) begin
                  wr.en    = 1'b1;
                  wr.op    = WR_EVICT;
                  wr.idx   = tail.old_idx;
                  count_in = tail.count - CNT_W'(1);
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.found_name     = found_ff;
               rsp_in.entries_in_use = count_ff[4:0];
               rsp_in.hits_total     = hits_ff;
               rsp_in.misses_total   = misses_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         last_check_ff <= '0;
         head_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         max_ff        <= 5'd16;
         ttl_ff        <= 32'd600;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         last_check_ff <= last_check_in;
         head_ff       <= head_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_ENTRIES: max_ff <= csr_wdata[4:0];
               CSR_TTL:         ttl_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/ttlc_checker.sv @@
module ttlc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ttlc_pkg::rsp_pkt_type rsp_data
);
   import ttlc_pkg::*;

   // A stalled result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A hit always returns a stored, non-empty name.
   a_hit_name: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_HIT) |-> rsp_data.found_name != 64'd0)
      else $error("hit with empty name");

   // Every other outcome returns no name.
   a_miss_name: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_HIT) |-> rsp_data.found_name == 64'd0)
      else $error("name returned without a hit");

endmodule

bind ttl_cache_oldest_evict_unit ttlc_checker u_ttlc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
